// ===== rtl/core/smv_pkg.sv =====
// shared types and constants of the stream mean and variance core
package smv_pkg;

  localparam int FracBits    = 8;
  localparam int MaxElements = 65536;

  localparam int ByteW  = 8;
  localparam int ValW   = 16;
  localparam int CountW = 17;
  localparam int SumW   = 32;
  localparam int SqW    = 48;
  localparam int SqHalf = SqW / 2;
  localparam int MulW   = 32;
  localparam int ProdW  = 2 * MulW;
  localparam int DenW   = 2 * (CountW - 1) + 1;
  localparam int DvdW   = ProdW + FracBits;
  localparam int DivCntW = $clog2(DvdW + 1);
  localparam int MeanW  = 24;
  localparam int VarW   = 40;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int ElemBytesW = 2;

  localparam logic [CfgIdxW-1:0]    RegElementBytes = 1'd0;
  localparam logic [CfgIdxW-1:0]    RegLeadSkip     = 1'd1;
  localparam logic [ElemBytesW-1:0] ElemBytesReset  = 2'd1;
  localparam logic [ElemBytesW-1:0] ElemBytesTwo    = 2'd2;
  localparam logic [CountW-1:0]     MaxCount        = CountW'(MaxElements);

  // steps of the closing arithmetic, one per cycle
  typedef enum logic [2:0] {
    FinNone,
    FinSq,
    FinNHi,
    FinNLo,
    FinDen,
    FinNum
  } fin_step_e;

  typedef enum logic {
    DivMean,
    DivVar
  } div_sel_e;

  typedef struct packed {
    logic      byte_en;
    fin_step_e fin_step;
    logic      div_start;
    div_sel_e  div_sel;
    logic      take_mean;
    logic      out_load;
  } smv_cmd_t;

  typedef struct packed {
    logic div_busy;
  } smv_status_t;

endpackage

// ===== rtl/core/smv_div.sv =====
// restoring divider, one quotient bit per cycle
module smv_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smv_pkg::DvdW-1:0]   dividend_i,
  input  logic [smv_pkg::DenW-1:0]   divisor_i,
  output logic                       busy_o,
  output logic [smv_pkg::DvdW-1:0]   quotient_o
);

  logic [smv_pkg::DenW-1:0]    rem_q, rem_d;
  logic [smv_pkg::DvdW-1:0]    dq_q, dq_d;
  logic [smv_pkg::DenW-1:0]    dsr_q, dsr_d;
  logic [smv_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [smv_pkg::DenW:0]      trial;
  logic [smv_pkg::DenW:0]      diff;
  logic                        qbit;

  assign trial = {rem_q, dq_q[smv_pkg::DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      dq_d  = dividend_i;
      dsr_d = divisor_i;
      cnt_d = smv_pkg::DivCntW'(smv_pkg::DvdW);
    end else if (cnt_q != '0) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_d = qbit ? diff[smv_pkg::DenW-1:0] : trial[smv_pkg::DenW-1:0];
      dq_d  = {dq_q[smv_pkg::DvdW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = dq_q;

endmodule

// ===== rtl/core/smv_dp.sv =====
// datapath: configuration, running sums, closing multiply and divide, result register
module smv_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smv_pkg::smv_cmd_t              cmd_i,
  output smv_pkg::smv_status_t           status_o,
  input  logic [smv_pkg::ByteW-1:0]      sample_byte_i,
  input  logic                           cfg_we_i,
  input  logic [smv_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smv_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic [smv_pkg::MeanW-1:0]      mean_q8_o,
  output logic [smv_pkg::VarW-1:0]       variance_q8_o,
  output logic                           is_monotonic_o,
  output logic                           is_increasing_o,
  output logic                           is_decreasing_o,
  output logic                           set_empty_o,
  output logic [smv_pkg::CountW-1:0]     element_total_o
);

  logic [smv_pkg::ElemBytesW-1:0] elem_bytes_q, elem_bytes_d;
  logic [smv_pkg::CfgDataW-1:0]   lead_skip_q, lead_skip_d;
  logic [smv_pkg::CfgDataW-1:0]   skip_left_q, skip_left_d;
  logic                           phase_q, phase_d;
  logic [smv_pkg::ByteW-1:0]      low_hold_q, low_hold_d;
  logic [smv_pkg::ValW-1:0]       prev_q, prev_d;
  logic [smv_pkg::CountW-1:0]     count_q, count_d;
  logic [smv_pkg::SumW-1:0]       sum_q, sum_d;
  logic [smv_pkg::SqW-1:0]        sumsq_q, sumsq_d;
  logic                           rising_q, rising_d;
  logic                           falling_q, falling_d;

  logic                           take;
  logic [smv_pkg::ValW-1:0]       elem;
  logic [2*smv_pkg::ValW-1:0]     elem_sq;

  // closing arithmetic
  logic [smv_pkg::MulW-1:0]       mul_a, mul_b;
  logic [smv_pkg::ProdW-1:0]      p_q;
  logic [smv_pkg::ProdW-1:0]      sq_q;
  logic [smv_pkg::ProdW-1:0]      acc_q;
  logic [smv_pkg::ProdW-1:0]      num_q;
  logic [smv_pkg::DenW-1:0]       den_q;
  logic [smv_pkg::MeanW-1:0]      mean_hold_q;

  logic [smv_pkg::DvdW-1:0]       div_dividend;
  logic [smv_pkg::DenW-1:0]       div_divisor;
  logic [smv_pkg::DvdW-1:0]       div_quot;
  logic                           div_busy;

  assign elem_sq = elem * elem;

  always_comb begin
    elem_bytes_d = elem_bytes_q;
    lead_skip_d  = lead_skip_q;
    skip_left_d  = skip_left_q;
    phase_d      = phase_q;
    low_hold_d   = low_hold_q;
    prev_d       = prev_q;
    count_d      = count_q;
    sum_d        = sum_q;
    sumsq_d      = sumsq_q;
    rising_d     = rising_q;
    falling_d    = falling_q;
    take         = 1'b0;
    elem         = {{(smv_pkg::ValW - smv_pkg::ByteW){1'b0}}, sample_byte_i};

    if (cmd_i.byte_en) begin
      if (skip_left_q != '0) begin
        skip_left_d = skip_left_q - 1'b1;
      end else if (elem_bytes_q == smv_pkg::ElemBytesTwo) begin
        if (!phase_q) begin
          low_hold_d = sample_byte_i;
          phase_d    = 1'b1;
        end else begin
          phase_d = 1'b0;
          take    = 1'b1;
          elem    = {sample_byte_i, low_hold_q};
        end
      end else begin
        phase_d = 1'b0;
        take    = 1'b1;
      end
    end

    // elements past the count limit leave everything untouched
    if (take && (count_q < smv_pkg::MaxCount)) begin
      if (count_q != '0) begin
        if (elem < prev_q) begin
          rising_d = 1'b0;
        end
        if (elem > prev_q) begin
          falling_d = 1'b0;
        end
      end
      prev_d  = elem;
      count_d = count_q + 1'b1;
      sum_d   = sum_q + smv_pkg::SumW'(elem);
      sumsq_d = sumsq_q + smv_pkg::SqW'(elem_sq);
    end

    if (cmd_i.out_load) begin
      skip_left_d = lead_skip_q;
      phase_d     = 1'b0;
      low_hold_d  = '0;
      prev_d      = '0;
      count_d     = '0;
      sum_d       = '0;
      sumsq_d     = '0;
      rising_d    = 1'b1;
      falling_d   = 1'b1;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        smv_pkg::RegElementBytes: begin
          elem_bytes_d = cfg_data_i[smv_pkg::ElemBytesW-1:0];
        end
        smv_pkg::RegLeadSkip: begin
          lead_skip_d = cfg_data_i;
          skip_left_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bytes_q <= smv_pkg::ElemBytesReset;
      lead_skip_q  <= '0;
      skip_left_q  <= '0;
      phase_q      <= 1'b0;
      low_hold_q   <= '0;
      prev_q       <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      sumsq_q      <= '0;
      rising_q     <= 1'b1;
      falling_q    <= 1'b1;
    end else begin
      elem_bytes_q <= elem_bytes_d;
      lead_skip_q  <= lead_skip_d;
      skip_left_q  <= skip_left_d;
      phase_q      <= phase_d;
      low_hold_q   <= low_hold_d;
      prev_q       <= prev_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      sumsq_q      <= sumsq_d;
      rising_q     <= rising_d;
      falling_q    <= falling_d;
    end
  end

  // n*sumsq is split into two halves to keep the multiplier at 32x32
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.fin_step)
      smv_pkg::FinSq: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      smv_pkg::FinNHi: begin
        mul_a = smv_pkg::MulW'(count_q);
        mul_b = smv_pkg::MulW'(sumsq_q[smv_pkg::SqW-1:smv_pkg::SqHalf]);
      end
      smv_pkg::FinNLo: begin
        mul_a = smv_pkg::MulW'(count_q);
        mul_b = smv_pkg::MulW'(sumsq_q[smv_pkg::SqHalf-1:0]);
      end
      smv_pkg::FinDen: begin
        mul_a = smv_pkg::MulW'(count_q);
        mul_b = smv_pkg::MulW'(count_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (cmd_i.fin_step)
      smv_pkg::FinNHi: sq_q  <= p_q;
      smv_pkg::FinNLo: acc_q <= p_q << smv_pkg::SqHalf;
      smv_pkg::FinDen: acc_q <= acc_q + p_q;
      smv_pkg::FinNum: begin
        num_q <= acc_q - sq_q;
        den_q <= p_q[smv_pkg::DenW-1:0];
      end
      default: begin
      end
    endcase
    if (cmd_i.take_mean) begin
      mean_hold_q <= div_quot[smv_pkg::MeanW-1:0];
    end
  end

  always_comb begin
    if (cmd_i.div_sel == smv_pkg::DivMean) begin
      div_dividend = smv_pkg::DvdW'(sum_q) << smv_pkg::FracBits;
      div_divisor  = smv_pkg::DenW'(count_q);
    end else begin
      div_dividend = smv_pkg::DvdW'(num_q) << smv_pkg::FracBits;
      div_divisor  = den_q;
    end
  end

  smv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  assign status_o.div_busy = div_busy;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (count_q == '0) begin
        mean_q8_o       <= '0;
        variance_q8_o   <= '0;
        is_monotonic_o  <= 1'b0;
        is_increasing_o <= 1'b0;
        is_decreasing_o <= 1'b0;
        set_empty_o     <= 1'b1;
        element_total_o <= '0;
      end else begin
        mean_q8_o       <= mean_hold_q;
        variance_q8_o   <= div_quot[smv_pkg::VarW-1:0];
        is_monotonic_o  <= rising_q | falling_q;
        is_increasing_o <= rising_q;
        is_decreasing_o <= falling_q;
        set_empty_o     <= 1'b0;
        element_total_o <= count_q;
      end
    end
  end

endmodule

// ===== rtl/core/smv_ctrl.sv =====
// controller: input and output handshakes and the closing sequence
module smv_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   final_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  smv_pkg::smv_status_t   status_i,
  output smv_pkg::smv_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_NHI    = 4'd2;
  localparam logic [3:0] S_NLO    = 4'd3;
  localparam logic [3:0] S_DEN    = 4'd4;
  localparam logic [3:0] S_NUM    = 4'd5;
  localparam logic [3:0] S_MSTART = 4'd6;
  localparam logic [3:0] S_MDIV   = 4'd7;
  localparam logic [3:0] S_VSTART = 4'd8;
  localparam logic [3:0] S_VDIV   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;
  logic       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.fin_step  = smv_pkg::FinNone;
    cmd_o.div_sel   = smv_pkg::DivMean;
    cmd_o.byte_en   = in_take;
    case (state_q)
      S_IDLE: begin
        if (in_take && final_byte_i) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.fin_step = smv_pkg::FinSq;
        state_d        = S_NHI;
      end
      S_NHI: begin
        cmd_o.fin_step = smv_pkg::FinNHi;
        state_d        = S_NLO;
      end
      S_NLO: begin
        cmd_o.fin_step = smv_pkg::FinNLo;
        state_d        = S_DEN;
      end
      S_DEN: begin
        cmd_o.fin_step = smv_pkg::FinDen;
        state_d        = S_NUM;
      end
      S_NUM: begin
        cmd_o.fin_step = smv_pkg::FinNum;
        state_d        = S_MSTART;
      end
      S_MSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MDIV;
      end
      S_MDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.take_mean = 1'b1;
          state_d         = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd_o.div_sel   = smv_pkg::DivVar;
        cmd_o.div_start = 1'b1;
        state_d         = S_VDIV;
      end
      S_VDIV: begin
        cmd_o.div_sel = smv_pkg::DivVar;
        if (!status_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        cmd_o.div_sel = smv_pkg::DivVar;
        // wait until the result register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/stream_mean_variance_monotonic_core.sv =====
// top level of the stream mean, variance and monotonic check core
//
// Input channel (in_valid_i / in_ready_o) carries one stream byte per
// transaction plus a flag marking the last byte of a data set. Leading bytes
// set by the lead_skip register are dropped, the rest form 1- or 2-byte
// little-endian elements (element_bytes register).
// Non-final bytes are taken one per cycle. A final byte starts the closing
// sequence: four products on one shared 32x32 multiplier, then two passes
// of a one-bit-per-cycle restoring divider over 64+FracBits dividend bits
// (mean, then variance). No byte is taken from the final byte until the
// result is loaded into the result register.
// The output channel (out_valid_o / out_ready_i) has its own result register:
// bytes of the next set flow in while a result waits; the next final byte is
// taken, and once its closing sequence is done the input holds until the
// receiver has taken the previous result.
// Reset clears the running sums, sets the rising and falling flags, sets
// element_bytes to 1 and lead_skip to 0, and drops any pending result.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
// once; a lead_skip write also restarts the skip count.
module stream_mean_variance_monotonic_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [smv_pkg::ByteW-1:0]      sample_byte_i,
  input  logic                           final_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [smv_pkg::MeanW-1:0]      mean_q8_o,
  output logic [smv_pkg::VarW-1:0]       variance_q8_o,
  output logic                           is_monotonic_o,
  output logic                           is_increasing_o,
  output logic                           is_decreasing_o,
  output logic                           set_empty_o,
  output logic [smv_pkg::CountW-1:0]     element_total_o,
  input  logic                           cfg_we_i,
  input  logic [smv_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smv_pkg::CfgDataW-1:0]   cfg_data_i
);

  smv_pkg::smv_cmd_t    cmd;
  smv_pkg::smv_status_t status;

  smv_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  smv_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .sample_byte_i   (sample_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mean_q8_o       (mean_q8_o),
    .variance_q8_o   (variance_q8_o),
    .is_monotonic_o  (is_monotonic_o),
    .is_increasing_o (is_increasing_o),
    .is_decreasing_o (is_decreasing_o),
    .set_empty_o     (set_empty_o),
    .element_total_o (element_total_o)
  );

endmodule
